FILE: sv/packed_time_rtc_with_alarm_core_defines.svh
// Assertion macros shared by the checker of the packed-time clock.
`ifndef PACKED_TIME_RTC_WITH_ALARM_CORE_DEFINES_SVH
`define PACKED_TIME_RTC_WITH_ALARM_CORE_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define PRTC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("clock core check failed");

// A condition in one cycle that requires another in the next cycle.
`define PRTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("clock core sequence check failed");

`endif

FILE: sv/prtc_pkg.sv
// Types and constants of the packed-time clock with alarm compare.
package prtc_pkg;

    // Access kinds carried in the mode field.
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;

    // Register map.
    localparam logic [2:0] REG_COUNTER = 3'd0;
    localparam logic [2:0] REG_MATCH   = 3'd1;
    localparam logic [2:0] REG_RELOAD  = 3'd2;
    localparam logic [2:0] REG_CONTROL = 3'd3;
    localparam logic [2:0] REG_RESTART = 3'd4;
    localparam logic [2:0] REG_RESET   = 3'd5;

    // Command words.
    localparam logic [31:0] CMD_RESTART = 32'h0000_005A;
    localparam logic [31:0] CMD_CLEAR   = 32'h0000_0099;

    // Rollover limits.
    localparam logic [5:0] SEC_MAX  = 6'd59;
    localparam logic [5:0] MIN_MAX  = 6'd59;
    localparam logic [4:0] HOUR_MAX = 5'd23;

    localparam int WAIT_W = 2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [2:0]  reg_index;
        logic [31:0] write_value;
    } req_t;

    typedef struct packed {
        logic [31:0] read_value;
        logic        alarm_pulse;
    } rsp_t;

    // Packed time: day(15) at bit 17, hour(5) at 12, min(6) at 6, sec(6) at 0.
    typedef struct packed {
        logic [14:0] day;
        logic [4:0]  hour;
        logic [5:0]  min;
        logic [5:0]  sec;
    } time_t;

endpackage

FILE: sv/prtc_in_stage.sv
// Input register of the packed-time clock: holds one accepted request word.
module prtc_in_stage
    import prtc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    input  logic take,
    output logic item_valid,
    output req_t item
);

    logic valid_reg;
    logic valid_next;
    req_t word_reg;

    // A held word leaves when the engine takes it, freeing the slot at once.
    assign req_ready  = !valid_reg || take;
    assign valid_next = (req_valid && req_ready) || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            word_reg <= req;
        end
    end

    assign item_valid = valid_reg;
    assign item       = word_reg;

endmodule

FILE: sv/prtc_engine.sv
// Clock state, register file and result register of the packed-time clock.
module prtc_engine
    import prtc_pkg::*;
#(
    parameter int RESTART_TICKS = 3
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic item_valid,
    input  req_t item,
    output logic take,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    time_t             time_reg;
    time_t             time_next;
    logic [31:0]       match_reg;
    logic [31:0]       match_next;
    logic [31:0]       reload_reg;
    logic [31:0]       reload_next;
    logic              run_reg;
    logic              run_next;
    logic              busy_reg;
    logic              busy_next;
    logic [WAIT_W-1:0] wait_reg;
    logic [WAIT_W-1:0] wait_next;
    logic              rsp_valid_reg;
    rsp_t              rsp_reg;
    rsp_t              rsp_next;
    logic              fire;
    time_t             adv_time;
    logic [WAIT_W-1:0] wait_dec;

    assign take = !rsp_valid_reg || rsp_ready;
    assign fire = item_valid && take;

    // One-second advance with carries through minutes, hours and days.
    always_comb
    begin
        adv_time = time_reg;
        if (time_reg.sec < SEC_MAX)
        begin
            adv_time.sec = time_reg.sec + 6'd1;
        end
        else
        begin
            adv_time.sec = 6'd0;
            if (time_reg.min < MIN_MAX)
            begin
                adv_time.min = time_reg.min + 6'd1;
            end
            else
            begin
                adv_time.min = 6'd0;
                if (time_reg.hour < HOUR_MAX)
                begin
                    adv_time.hour = time_reg.hour + 5'd1;
                end
                else
                begin
                    adv_time.hour = 5'd0;
                    adv_time.day  = time_reg.day + 15'd1;
                end
            end
        end
    end

    assign wait_dec = wait_reg - {{(WAIT_W-1){1'b0}}, 1'b1};

    always_comb
    begin
        logic changed;
        changed     = 1'b0;
        time_next   = time_reg;
        match_next  = match_reg;
        reload_next = reload_reg;
        run_next    = run_reg;
        busy_next   = busy_reg;
        wait_next   = wait_reg;
        rsp_next    = '0;
        case (item.mode)
            MODE_TICK:
            begin
                // A pending restart counts down even while the clock is stopped.
                if (busy_reg)
                begin
                    wait_next = wait_dec;
                    if (wait_dec == '0)
                    begin
                        time_next = time_t'(reload_reg);
                        busy_next = 1'b0;
                        changed   = 1'b1;
                    end
                end
                else if (run_reg)
                begin
                    time_next = adv_time;
                    changed   = 1'b1;
                end
                rsp_next.alarm_pulse = changed
                    && (time_next.sec  == match_reg[5:0])
                    && (time_next.min  == match_reg[11:6])
                    && (time_next.hour == match_reg[16:12]);
            end
            MODE_READ:
            begin
                case (item.reg_index)
                    REG_COUNTER: rsp_next.read_value = 32'(time_reg);
                    REG_MATCH:   rsp_next.read_value = match_reg;
                    REG_RELOAD:  rsp_next.read_value = reload_reg;
                    REG_CONTROL: rsp_next.read_value = {26'd0, busy_reg, 4'd0, run_reg};
                    default:     rsp_next.read_value = 32'd0;
                endcase
            end
            MODE_WRITE:
            begin
                case (item.reg_index)
                    REG_MATCH:   match_next  = item.write_value;
                    REG_RELOAD:  reload_next = item.write_value;
                    REG_CONTROL: run_next    = item.write_value[0];
                    REG_RESTART:
                    begin
                        if (item.write_value == CMD_RESTART)
                        begin
                            busy_next = 1'b1;
                            wait_next = WAIT_W'(RESTART_TICKS);
                        end
                    end
                    REG_RESET:
                    begin
                        if (item.write_value == CMD_CLEAR)
                        begin
                            time_next = '0;
                        end
                    end
                    default:
                    begin
                        time_next = time_reg;
                    end
                endcase
            end
            default:
            begin
                rsp_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg      <= '0;
            match_reg     <= '0;
            reload_reg    <= '0;
            run_reg       <= 1'b0;
            busy_reg      <= 1'b0;
            wait_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                time_reg   <= time_next;
                match_reg  <= match_next;
                reload_reg <= reload_next;
                run_reg    <= run_next;
                busy_reg   <= busy_next;
                wait_reg   <= wait_next;
            end
            if (take)
            begin
                rsp_valid_reg <= item_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: sv/packed_time_rtc_with_alarm_core.sv
// Top level of the packed-time real-time clock with alarm compare.
// Each request word is a one-second tick, a register read or a register write, and each
// gives exactly one response word. A request is registered in the input register on acceptance,
// and its response is loaded into the result register when the engine takes the word; a
// response that is not yet taken holds the engine off. The input register and the result
// register together take a new request every cycle while the response side keeps up.
// The clock state is updated in the same cycle the result is registered, so consecutive
// requests see each other's effects in order. A restart command loads the reload word
// RESTART_TICKS ticks (1 to 3) after it is written.
module packed_time_rtc_with_alarm_core
    import prtc_pkg::*;
#(
    parameter int RESTART_TICKS = 3
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    logic take;
    logic item_valid;
    req_t item;

    prtc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    prtc_engine #(
        .RESTART_TICKS (RESTART_TICKS)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp)
    );

endmodule

FILE: sv/prtc_checker.sv
// Port-level checker of the packed-time clock and its bind to the top level.
`include "packed_time_rtc_with_alarm_core_defines.svh"

module prtc_checker
    import prtc_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input req_t req,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    logic [1:0] inflight_reg;
    logic [1:0] inflight_next;
    logic       req_acc;
    logic       rsp_acc;

    assign req_acc = req_valid && req_ready;
    assign rsp_acc = rsp_valid && rsp_ready;

    // Words accepted whose responses have not yet been taken.
    always_comb
    begin
        inflight_next = inflight_reg;
        if (req_acc && !rsp_acc)
        begin
            inflight_next = inflight_reg + 2'd1;
        end
        else if (!req_acc && rsp_acc)
        begin
            inflight_next = inflight_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= 2'd0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    `PRTC_ASSERT_NEXT(a_req_hold, clk, rst_n, req_valid && !req_ready, req_valid && $stable(req))
    `PRTC_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
    `PRTC_ASSERT(a_ready_when_out_empty, clk, rst_n, !rsp_valid |-> req_ready)
    `PRTC_ASSERT(a_rsp_has_request, clk, rst_n, rsp_valid |-> inflight_reg != 2'd0)
    `PRTC_ASSERT(a_capacity, clk, rst_n, inflight_reg != 2'd3)

endmodule

bind packed_time_rtc_with_alarm_core prtc_checker u_prtc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
